/* design/ots_pkg.sv */
// Package for the token splitter: codes, sizes, command and status types.
// Used by ots_ctrl, ots_datapath and obfuscation_token_splitter.
// No dependencies.
`default_nettype none

package ots_pkg;

  localparam int MaxToken  = 16;
  localparam int StoreCap  = (MaxToken < 16) ? MaxToken : 16;
  localparam int IdxW      = $clog2(StoreCap);
  localparam int FillW     = $clog2(StoreCap + 1);
  localparam int PctLen    = 3;
  localparam int PrefixLen = 5;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_UPPER_C = 8'h43;

  typedef enum logic [1:0] {
    KIND_PERCENT = 2'd0,
    KIND_ENTITY  = 2'd1,
    KIND_CALL    = 2'd2,
    KIND_LETTER  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_PERCENT = 3'd1,
    MODE_ENTITY  = 3'd2,
    MODE_PREFIX  = 3'd3,
    MODE_CALL    = 3'd4
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic item_left;
    logic item_final;
    logic out_free;
  } dp_status_t;

  // expected byte of the call prefix at position idx
  function automatic logic [7:0] pat_char(input logic upper, input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h72;
      default: c = CH_LPAREN;
    endcase
    if (upper && idx < 3'(PrefixLen - 1)) begin
      c = c & 8'hdf;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/ots_ctrl.sv */
// Controller state machine of the token splitter: accept, then emit items.
// Depends on ots_pkg.
`default_nettype none

module ots_ctrl
  import ots_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.item_left) begin
          state_next = ST_IDLE;
        end else if (status.out_free && status.item_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EMIT: begin
        cmd.load = status.item_left && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/ots_datapath.sv */
// Datapath of the token splitter: scan state, token store, emission counters,
// output register. Depends on ots_pkg.
`default_nettype none

module ots_datapath
  import ots_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire        [7:0] in_byte,
  input  wire              in_eos,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             out_valid,
  input  wire              out_ready,
  output logic       [7:0] out_byte,
  output kind_t            out_kind,
  output logic             out_tok_last,
  output logic             out_ovf,
  output logic             out_run_last
);

  logic [7:0]       store [StoreCap];
  mode_t            mode, mode_next;
  logic [FillW-1:0] fill, fill_next;
  logic [2:0]       matched, matched_next;
  logic             upper, upper_next;
  logic             cut, cut_next;

  logic [7:0]       hold_b;
  logic [FillW-1:0] blen, blen_next;
  logic [FillW-1:0] bidx;
  kind_t            bkind, bkind_next;
  logic             brel, brel_next;
  logic             bovf, bovf_next;
  logic             tail, tail_next;
  logic             pend, pend_next;

  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;

  logic             starter, is_c, match, term, can_keep;
  logic [FillW-1:0] fill_k;
  logic [2:0]       matched_k;

  logic             burst_active, burst_end;
  logic [7:0]       cand_byte;
  kind_t            cand_kind;
  logic             cand_tok_last, cand_ovf;

  // decode of the accepted byte
  always_comb begin
    is_c     = (in_byte == CH_LOWER_C) || (in_byte == CH_UPPER_C);
    starter  = is_c || (in_byte == CH_PERCENT) || (in_byte == CH_AMP);
    match    = (matched < 3'(PrefixLen)) && (in_byte == pat_char(upper, matched));
    can_keep = fill < FillW'(StoreCap);
    fill_k   = can_keep ? fill + FillW'(1) : fill;
    matched_k = matched + 3'd1;
    case (mode)
      MODE_PERCENT: term = fill_k >= FillW'(PctLen);
      MODE_ENTITY:  term = in_byte == CH_SEMI;
      MODE_CALL:    term = in_byte == CH_RPAREN;
      default:      term = 1'b0;
    endcase

    mode_next    = mode;
    fill_next    = fill;
    matched_next = matched;
    upper_next   = upper;
    cut_next     = cut;
    blen_next    = '0;
    bkind_next   = KIND_LETTER;
    brel_next    = 1'b0;
    bovf_next    = 1'b0;
    tail_next    = 1'b0;
    pend_next    = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = fill[IdxW-1:0];

    if (mode == MODE_START || (mode == MODE_PREFIX && !match)) begin
      brel_next    = 1'b1;
      blen_next    = (mode == MODE_PREFIX) ? FillW'(matched) : '0;
      tail_next    = !starter || (is_c && in_eos);
      mode_next    = MODE_START;
      fill_next    = '0;
      matched_next = '0;
      upper_next   = 1'b0;
      cut_next     = 1'b0;
      if (starter && !in_eos) begin
        fill_next = FillW'(1);
        if (in_byte == CH_PERCENT) begin
          mode_next = MODE_PERCENT;
        end else if (in_byte == CH_AMP) begin
          mode_next = MODE_ENTITY;
        end else begin
          mode_next    = MODE_PREFIX;
          matched_next = 3'd1;
          upper_next   = in_byte == CH_UPPER_C;
        end
        if (blen_next == '0) begin
          wr_en  = 1'b1;
          wr_idx = '0;
        end else begin
          pend_next = 1'b1;
        end
      end
    end else if (mode == MODE_PREFIX) begin
      wr_en        = 1'b1;
      fill_next    = fill + FillW'(1);
      matched_next = matched_k;
      if (matched_k == 3'(PrefixLen)) begin
        mode_next    = MODE_CALL;
        matched_next = '0;
      end
      if (in_eos) begin
        if (matched_k != 3'(PrefixLen)) begin
          brel_next = 1'b1;
          blen_next = FillW'(matched_k);
        end
        mode_next    = MODE_START;
        fill_next    = '0;
        matched_next = '0;
        upper_next   = 1'b0;
        cut_next     = 1'b0;
      end
    end else begin
      wr_en     = can_keep;
      fill_next = fill_k;
      cut_next  = cut || !can_keep;
      if (term) begin
        blen_next = fill_k;
        bovf_next = cut || !can_keep;
        case (mode)
          MODE_PERCENT: bkind_next = KIND_PERCENT;
          MODE_ENTITY:  bkind_next = KIND_ENTITY;
          default:      bkind_next = KIND_CALL;
        endcase
      end
      if (term || in_eos) begin
        mode_next    = MODE_START;
        fill_next    = '0;
        matched_next = '0;
        upper_next   = 1'b0;
        cut_next     = 1'b0;
      end
    end
  end

  // candidate result item
  always_comb begin
    burst_active = bidx < blen;
    burst_end    = (bidx + FillW'(1)) == blen;
    cand_byte    = burst_active ? store[bidx[IdxW-1:0]] : hold_b;
    cand_kind    = burst_active ? bkind : KIND_LETTER;
    cand_tok_last = burst_active ? (brel || burst_end) : 1'b1;
    cand_ovf     = burst_active && bovf;
    status.item_left  = burst_active || tail;
    status.item_final = burst_active ? (burst_end && !tail) : 1'b1;
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_START;
      fill      <= '0;
      matched   <= '0;
      upper     <= 1'b0;
      cut       <= 1'b0;
      blen      <= '0;
      bidx      <= '0;
      tail      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mode    <= mode_next;
        fill    <= fill_next;
        matched <= matched_next;
        upper   <= upper_next;
        cut     <= cut_next;
        blen    <= blen_next;
        bidx    <= '0;
        tail    <= tail_next;
        pend    <= pend_next;
      end else if (cmd.load) begin
        if (burst_active) begin
          bidx <= bidx + FillW'(1);
        end else begin
          tail <= 1'b0;
        end
        if (status.item_final) begin
          pend <= 1'b0;
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_b <= in_byte;
      bkind  <= bkind_next;
      brel   <= brel_next;
      bovf   <= bovf_next;
      if (wr_en) begin
        store[wr_idx] <= in_byte;
      end
    end else if (cmd.load && pend && status.item_final) begin
      store[0] <= hold_b;
    end
    if (cmd.load) begin
      out_byte     <= cand_byte;
      out_kind     <= cand_kind;
      out_tok_last <= cand_tok_last;
      out_ovf      <= cand_ovf;
      out_run_last <= status.item_final;
    end
  end

endmodule

`default_nettype wire

/* design/obfuscation_token_splitter.sv */
// Top level of the token splitter: controller and datapath.
// Depends on ots_pkg, ots_ctrl, ots_datapath.
//
//  channel | direction | tdata          | tuser                         | tlast
//  s_*     | in        | [7:0] in_byte  | -                             | end_of_string
//  m_*     | out       | [7:0] token    | [1:0] kind [2] tok_last [3] ovf | run_last
//
// Each input byte is accepted in the idle state, then its result items are
// loaded in the emit state, which is entered even when the byte gives none.
// Results leave one at a time; stored token bytes pass the single read port of the store.
// Reset clears the scan state; a stalled m_tready holds the current item
// and the next input byte is taken once the previous run has been loaded.
`default_nettype none

module obfuscation_token_splitter
  import ots_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] in_byte
  input  wire        s_tlast,
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] token_byte
  output logic [3:0] m_tuser,   // [1:0] token_kind, [2] token_last, [3] token_overflow
  output logic       m_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;
  kind_t      out_kind;
  logic       out_tok_last;
  logic       out_ovf;

  ots_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ots_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (s_tdata),
    .in_eos       (s_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .out_kind     (out_kind),
    .out_tok_last (out_tok_last),
    .out_ovf      (out_ovf),
    .out_run_last (m_tlast)
  );

  assign m_tuser = {out_ovf, out_tok_last, out_kind};

endmodule

`default_nettype wire

/* verif/obfuscation_token_splitter_tb.sv */
// Testbench for obfuscation_token_splitter: drives byte strings, predicts the
// token items and checks every output item field by field.
// Depends on ots_pkg and the obfuscation_token_splitter RTL.
`default_nettype none

module obfuscation_token_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ots_pkg::*;

  localparam int Gap        = 17;
  localparam int IdleLimit  = 2000;
  localparam int TailCycles = 20;
  localparam int RunCap     = 16;
  localparam int HoldOff    = 300;

  typedef struct packed {
    logic [7:0] tok;
    kind_t      kind;
    logic       tok_last;
    logic       ovf;
    logic       run_last;
  } token_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_byte
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] token_byte
  logic [3:0] m_tuser;   // [1:0] token_kind, [2] token_last, [3] token_overflow
  logic       m_tlast;

  token_item_t expected_tokens[$];
  token_item_t run_items[$];

  mode_t      tok_mode;
  logic [7:0] tok_store [StoreCap];
  int         tok_fill;
  int         call_seen;
  logic       call_caps;
  logic       tok_cut;

  int send_gap_max = Gap;
  int recv_gap_max = Gap;
  int hold_cycles  = 0;
  int items_sent   = 0;
  int mismatches   = 0;
  int stall_count  = 0;

  obfuscation_token_splitter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] call_char(input logic caps, input int idx);
    case (idx)
      0:       return caps ? CH_UPPER_C : CH_LOWER_C;
      1:       return caps ? "H" : "h";
      2:       return caps ? "A" : "a";
      3:       return caps ? "R" : "r";
      default: return CH_LPAREN;
    endcase
  endfunction

  function automatic void note_result(input logic [7:0] b, input kind_t k, input logic last,
                                      input logic ovf);
    token_item_t t;
    if (run_items.size() < RunCap) begin
      t.tok      = b;
      t.kind     = k;
      t.tok_last = last;
      t.ovf      = ovf;
      t.run_last = 1'b0;
      run_items.push_back(t);
    end
  endfunction

  function automatic void clear_scan();
    tok_mode  = MODE_START;
    tok_fill  = 0;
    call_seen = 0;
    call_caps = 1'b0;
    tok_cut   = 1'b0;
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    if (tok_fill < StoreCap) begin
      tok_store[tok_fill] = b;
      tok_fill++;
    end else begin
      tok_cut = 1'b1;
    end
  endfunction

  function automatic void flush_as(input kind_t k);
    for (int i = 0; i < tok_fill; i++) begin
      note_result(tok_store[i], k, i + 1 == tok_fill, tok_cut);
    end
    clear_scan();
  endfunction

  function automatic void release_call_prefix();
    for (int i = 0; i < call_seen && i < tok_fill; i++) begin
      note_result(tok_store[i], KIND_LETTER, 1'b1, 1'b0);
    end
    clear_scan();
  endfunction

  function automatic void open_token(input logic [7:0] b);
    clear_scan();
    if (b == CH_PERCENT) begin
      keep_byte(b);
      tok_mode = MODE_PERCENT;
    end else if (b == CH_AMP) begin
      keep_byte(b);
      tok_mode = MODE_ENTITY;
    end else if (b == CH_LOWER_C || b == CH_UPPER_C) begin
      keep_byte(b);
      call_seen = 1;
      call_caps = (b == CH_UPPER_C);
      tok_mode  = MODE_PREFIX;
    end else begin
      note_result(b, KIND_LETTER, 1'b1, 1'b0);
    end
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic eos);
    token_item_t t;
    run_items.delete();
    case (tok_mode)
      MODE_PERCENT: begin
        keep_byte(b);
        if (tok_fill >= PctLen) flush_as(KIND_PERCENT);
      end
      MODE_ENTITY: begin
        keep_byte(b);
        if (b == CH_SEMI) flush_as(KIND_ENTITY);
      end
      MODE_CALL: begin
        keep_byte(b);
        if (b == CH_RPAREN) flush_as(KIND_CALL);
      end
      MODE_PREFIX: begin
        if (call_seen < PrefixLen && b == call_char(call_caps, call_seen)) begin
          keep_byte(b);
          call_seen++;
          if (call_seen >= PrefixLen) begin
            tok_mode  = MODE_CALL;
            call_seen = 0;
          end
        end else begin
          release_call_prefix();
          open_token(b);
        end
      end
      default: open_token(b);
    endcase
    if (eos) begin
      if (tok_mode == MODE_PREFIX) release_call_prefix();
      clear_scan();
    end
    if (run_items.size() > 0) begin
      t = run_items.pop_back();
      t.run_last = 1'b1;
      run_items.push_back(t);
    end
    foreach (run_items[i]) expected_tokens.push_back(run_items[i]);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] specials [7];
    specials = '{CH_PERCENT, CH_AMP, CH_LOWER_C, CH_UPPER_C, CH_SEMI, CH_RPAREN, CH_LPAREN};
    if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] body_byte(input logic [7:0] term);
    logic [7:0] b;
    b = rand_byte();
    return (b == term) ? 8'h78 : b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do begin
      @(posedge clk);
    end while (!s_tready);
    split_byte(b, eos);
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_byte(txt[i], i == txt.len() - 1);
    end
  endtask

  task automatic random_strings(input int count);
    logic [7:0] s[$];
    int         stop_at;
    int         len;
    logic       caps;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      s.delete();
      repeat ($urandom_range(1, 6)) begin
        caps = 1'($urandom_range(0, 1));
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 4);
        case ($urandom_range(0, 9))
          0, 1: begin
            s.push_back(CH_PERCENT);
            s.push_back(rand_byte());
            s.push_back(rand_byte());
          end
          2, 3: begin
            s.push_back(CH_AMP);
            repeat (len) s.push_back(body_byte(CH_SEMI));
            s.push_back(CH_SEMI);
          end
          4, 5: begin
            for (int i = 0; i < PrefixLen; i++) s.push_back(call_char(caps, i));
            repeat (len) s.push_back(body_byte(CH_RPAREN));
            s.push_back(CH_RPAREN);
          end
          6: begin
            // broken prefix, sometimes with mixed case
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
              s.push_back(call_char(($urandom_range(0, 3) == 0) ? !caps : caps, i));
            end
            s.push_back(rand_byte());
          end
          default: s.push_back(rand_byte());
        endcase
      end
      if ($urandom_range(0, 5) == 0 && s.size() > 1) begin
        repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
      end
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    end
  endtask

  task automatic test_directed_tokens();
    send_byte(CH_PERCENT, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("&x;");
    send_text("CHAR()");
    send_text("cHa");
    send_text("ch");
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_text("&q");
    send_text("%");
  endtask

  task automatic test_random_traffic();
    random_strings(270);
  endtask

  task automatic test_back_to_back();
    send_gap_max = 0;
    recv_gap_max = 0;
    random_strings(60);
    send_gap_max = Gap;
    recv_gap_max = Gap;
  endtask

  task automatic test_output_hold();
    send_gap_max = 0;
    hold_cycles  = HoldOff;
    random_strings(40);
    send_gap_max = Gap;
  endtask

  task automatic test_drain_pause();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_tokens.size() != 0);
    repeat (TailCycles) @(posedge clk);
    random_strings(30);
  endtask

  initial begin
    int gap;
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, recv_gap_max);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_tokens
    token_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: byte %h kind %0d last %0b ovf %0b run_last %0b",
                   m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3], m_tlast);
        end
      end else begin
        want = expected_tokens.pop_front();
        if (m_tdata !== want.tok || m_tuser[1:0] !== want.kind ||
            m_tuser[2] !== want.tok_last || m_tuser[3] !== want.ovf ||
            m_tlast !== want.run_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("item mismatch: expected byte %h kind %0d last %0b ovf %0b run_last %0b",
                     want.tok, want.kind, want.tok_last, want.ovf, want.run_last);
            $display("                    got byte %h kind %0d last %0b ovf %0b run_last %0b",
                     m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3], m_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_tokens();
    test_random_traffic();
    test_back_to_back();
    test_output_hold();
    test_drain_pause();
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* obfuscation_token_splitter.f */
design/ots_pkg.sv
design/ots_ctrl.sv
design/ots_datapath.sv
design/obfuscation_token_splitter.sv
verif/obfuscation_token_splitter_tb.sv
